/* rtl/brnc_pkg.sv */
package brnc_pkg;

  // Raster limits and derived widths
  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned MaxRows    = 1024;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned RowW       = $clog2(MaxRows + 2);
  localparam int unsigned CfgW       = 11;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CountW     = 4;
  localparam int unsigned WinW       = 9;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegRowCount    = 2'd0,
    RegColumnCount = 2'd1
  } cfg_reg_e;

  // Edge masks for one reported cell
  typedef struct packed {
    logic left_ok;
    logic top_ok;
    logic bot_ok;
  } win_mask_t;

endpackage

/* rtl/brnc_cell_if.sv */
interface brnc_cell_if;
  logic valid;
  logic ready;
  logic cell_bit;

  modport source (output valid, output cell_bit, input ready);
  modport sink (input valid, input cell_bit, output ready);
endinterface

/* rtl/brnc_result_if.sv */
interface brnc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] neighbour_count;
  logic       centre_set;
  logic       last_cell;

  modport source (output valid, output neighbour_count, output centre_set,
                  output last_cell, input ready);
  modport sink (input valid, input neighbour_count, input centre_set,
                input last_cell, output ready);
endinterface

/* rtl/brnc_line_buf.sv */
module brnc_line_buf import brnc_pkg::*; (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [ColW-1:0] wr_addr_i,
  input  logic [1:0]      wr_data_i,
  input  logic            rd_en_i,
  input  logic [ColW-1:0] rd_addr_i,
  output logic [1:0]      rd_data_o
);

  // One entry per column: {two rows back, one row back}
  logic [1:0] mem_q [MaxColumns];
  logic [1:0] rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/brnc_count.sv */
module brnc_count import brnc_pkg::*; (
  input  logic [WinW-1:0]   view_i,
  input  win_mask_t         mask_i,
  output logic [CountW-1:0] count_o,
  output logic              centre_o
);

  logic [WinW-1:0]   gated;
  logic [CountW-1:0] sum;

  // Drop neighbours beyond the raster edges; view is centred on bit 4
  always_comb begin
    gated = view_i;
    gated[4] = 1'b0;
    if (!mask_i.left_ok) begin
      gated[2:0] = 3'b000;
    end
    if (!mask_i.top_ok) begin
      gated[0] = 1'b0;
      gated[3] = 1'b0;
      gated[6] = 1'b0;
    end
    if (!mask_i.bot_ok) begin
      gated[2] = 1'b0;
      gated[5] = 1'b0;
      gated[8] = 1'b0;
    end
  end

  // Add the eight neighbours
  always_comb begin
    sum = '0;
    for (int i = 0; i < WinW; i++) begin
      sum = sum + CountW'(gated[i]);
    end
  end

  assign centre_o = view_i[4];
  assign count_o  = view_i[4] ? '0 : sum;

endmodule

/* rtl/binary_raster_neighbour_count_top.sv */
// Streams a binary raster in raster order, one cell per transaction, and
// returns for each cell the number of set cells among its eight neighbours
// (cells outside the raster count as clear; a set cell reports 0 with
// centre_set high). A new cell is taken every clock unless the result
// output stalls; the result for a cell comes out column_count+1
// transactions after it, so after the last cell send column_count+1 padding
// transactions (bit ignored) to drain the raster, the last result carrying
// last_cell. The first column_count+1 transactions of a raster give no
// result. A result is presented once the transaction that releases it has
// passed through stage one, loaded together with the line-buffer read, and
// then the result register. Any register write restarts the raster; write
// only while the block is idle. Register values of 0 act as 1, values
// above 1024 act as 1024.
module binary_raster_neighbour_count_top import brnc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  brnc_cell_if.sink          in_i,
  brnc_result_if.source      out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam logic [CfgW-1:0] MaxRowsC = CfgW'(MaxRows);
  localparam logic [CfgW-1:0] MaxColsC = CfgW'(MaxColumns);

  // Configuration and position
  logic [CfgW-1:0] rows_q, cols_q;
  logic [RowW-1:0] rows_eff, cols_eff, rows_p1;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] col_ext, col_p1;

  // Stage one
  logic            s1_valid_q, s1_valid_d;
  logic [ColW-1:0] s1_col_q;
  logic            s1_bit_q;
  logic            s1_emit_q;
  logic            s1_col0_q;
  win_mask_t       s1_mask_q;
  logic            s1_last_q;
  logic            fwd_q;
  logic [1:0]      fwd_data_q;
  logic            s1_move;

  // Stage zero decode
  logic            accept;
  logic            emit0, emit1, bit_eff;
  win_mask_t       mask_d;
  logic            last_d;
  logic            fwd_d;

  // Window and results
  logic [1:0]        rd_data, line_data;
  logic [WinW-1:0]   window_q, window_n, view;
  logic [CountW-1:0] count;
  logic              centre;
  logic              out_free;
  logic              out_valid_q;
  logic [CountW-1:0] out_count_q;
  logic              out_centre_q, out_last_q;

  // Clamp the registers to their usable range
  always_comb begin
    rows_eff = (rows_q == '0) ? RowW'(1) : (rows_q > MaxRowsC) ? RowW'(MaxRowsC) : RowW'(rows_q);
    cols_eff = (cols_q == '0) ? RowW'(1) : (cols_q > MaxColsC) ? RowW'(MaxColsC) : RowW'(cols_q);
  end

  assign rows_p1 = rows_eff + RowW'(1);
  assign col_ext = RowW'(col_q);
  assign col_p1  = col_ext + RowW'(1);

  // Handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_move    = s1_valid_q && (!s1_emit_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign accept     = in_i.valid && in_i.ready;

  // Decode the incoming transaction against its position
  always_comb begin
    emit0   = (col_q == '0) && (row_q >= RowW'(2));
    emit1   = (col_q != '0) && (row_q >= RowW'(1)) && (row_q <= rows_eff);
    bit_eff = (row_q < rows_eff) ? in_i.cell_bit : 1'b0;
    if (col_q == '0) begin
      mask_d.left_ok = (cols_eff > RowW'(1));
      mask_d.top_ok  = (row_q >= RowW'(3));
      mask_d.bot_ok  = (row_q <= rows_eff);
      last_d         = (row_q == rows_p1);
    end else begin
      mask_d.left_ok = (col_q >= ColW'(2));
      mask_d.top_ok  = (row_q >= RowW'(2));
      mask_d.bot_ok  = (row_q < rows_eff);
      last_d         = 1'b0;
    end
    fwd_d = s1_move && (s1_col_q == col_q);
  end

  // Advance the raster position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (row_q >= rows_p1) begin
      row_d = '0;
      col_d = '0;
    end else if (col_p1 >= cols_eff) begin
      row_d = row_q + RowW'(1);
      col_d = '0;
    end else begin
      col_d = col_p1[ColW-1:0];
    end
  end

  // Registers and position; any register write restarts the raster
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgW'(1);
      cols_q <= CfgW'(1);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRowCount: begin
          rows_q <= cfg_data_i;
          row_q  <= '0;
          col_q  <= '0;
        end
        RegColumnCount: begin
          cols_q <= cfg_data_i;
          row_q  <= '0;
          col_q  <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Stage one control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= col_q;
      s1_bit_q   <= bit_eff;
      s1_emit_q  <= emit0 || emit1;
      s1_col0_q  <= (col_q == '0);
      s1_mask_q  <= mask_d;
      s1_last_q  <= last_d;
      fwd_q      <= fwd_d;
      fwd_data_q <= {line_data[0], s1_bit_q};
    end
  end

  // Line buffers: read on accept, write back when stage one moves on
  brnc_line_buf u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({line_data[0], s1_bit_q}),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data)
  );

  // Take the column just written when the same column is read back
  assign line_data = fwd_q ? fwd_data_q : rd_data;

  // Shift the new column in; bit = column*3 + row
  assign window_n = {s1_bit_q, line_data[0], line_data[1], window_q[WinW-1:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (s1_move) begin
      window_q <= window_n;
    end
  end

  // Centre the view on the reported cell
  assign view = s1_col0_q ? {3'b000, window_q[WinW-1:3]} : window_n;

  brnc_count u_count (
    .view_i   (view),
    .mask_i   (s1_mask_q),
    .count_o  (count),
    .centre_o (centre)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_emit_q) begin
      out_count_q  <= count;
      out_centre_q <= centre;
      out_last_q   <= s1_last_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.neighbour_count = out_count_q;
  assign out_o.centre_set      = out_centre_q;
  assign out_o.last_cell       = out_last_q;

  // A result only appears after an emitting stage-one item moved on
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_emit_q))
    else $error("result without a releasing item");

  // A set centre reports zero, and counts never exceed eight
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_count_q <= CountW'(8)) && (!out_centre_q || out_count_q == '0)))
    else $error("neighbour count out of range");

  // The final drain transaction wraps the raster position
  a_raster_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && row_q >= rows_p1) |=> (row_q == '0 && col_q == '0))
    else $error("raster position did not wrap");

endmodule
